>>> hw/rtl/rbf_pkg.sv
// shared types, constants and reciprocal table for the row box filter
package rbf_pkg;

    // reciprocal scaling for the divide-by-width multiply
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 21;
    localparam int FSIZE_W     = 4;
    localparam int SAMPLE_W    = 8;

    // datapath commands issued by the controller
    typedef struct packed {
        logic push_in;    // shift the accepted sample into the window
        logic push_zero;  // shift a zero in (flush beyond the row end)
        logic clear;      // empty window and sum
        logic emit;       // load the output register
        logic done_flag;  // row_done value for the loaded output
    } t_dp_cmd;

    // ceil(2^RECIP_SHIFT / d), exact quotient for sums below 2^16
    function automatic logic [RECIP_W-1:0] recip(input logic [4:0] d);
        logic [RECIP_W-1:0] r;
        unique case (d)
            5'd2:    r = 21'd524288;
            5'd3:    r = 21'd349526;
            5'd4:    r = 21'd262144;
            5'd5:    r = 21'd209716;
            5'd6:    r = 21'd174763;
            5'd7:    r = 21'd149797;
            5'd8:    r = 21'd131072;
            5'd9:    r = 21'd116509;
            5'd10:   r = 21'd104858;
            5'd11:   r = 21'd95326;
            5'd12:   r = 21'd87382;
            5'd13:   r = 21'd80660;
            5'd14:   r = 21'd74899;
            5'd15:   r = 21'd69906;
            5'd16:   r = 21'd65536;
            default: r = 21'd1048576;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/rbf_datapath.sv
// window shift line, running sum, reciprocal multiply and output register
module rbf_datapath #(
    parameter int MAX_TAPS = 8,
    localparam int TAP_W = $clog2(MAX_TAPS + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rbf_pkg::t_dp_cmd               i_cmd,
    input  logic [rbf_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [rbf_pkg::FSIZE_W-1:0]    i_filter_size,
    output logic [TAP_W-1:0]               o_taps,
    output logic [rbf_pkg::SAMPLE_W-1:0]   o_filtered,
    output logic                           o_row_done
);
    localparam int SUM_W  = rbf_pkg::SAMPLE_W + $clog2(MAX_TAPS);
    localparam int IDX_W  = $clog2(MAX_TAPS);
    localparam int PROD_W = SUM_W + rbf_pkg::RECIP_W;

    logic [rbf_pkg::SAMPLE_W-1:0] r_win [MAX_TAPS];
    logic [SUM_W-1:0]             r_sum;
    logic [PROD_W-1:0]            r_prod;
    logic [rbf_pkg::SAMPLE_W-1:0] r_filtered;
    logic                         r_row_done;

    logic [4:0]                   fs_ext;
    logic [TAP_W-1:0]             taps;
    logic [rbf_pkg::SAMPLE_W-1:0] push_val;
    logic [rbf_pkg::SAMPLE_W-1:0] leaving;
    logic [SUM_W-1:0]             n_sum;

    assign fs_ext = {1'b0, i_filter_size};

    // zero acts as one, above the window depth acts as full depth
    always_comb begin
        priority if (fs_ext == 5'd0) begin
            taps = TAP_W'(1);
        end else if (fs_ext > 5'(MAX_TAPS)) begin
            taps = TAP_W'(MAX_TAPS);
        end else begin
            taps = TAP_W'(fs_ext);
        end
    end

    assign push_val = i_cmd.push_in ? i_sample : '0;
    assign leaving  = r_win[IDX_W'(taps - TAP_W'(1))];
    assign n_sum    = r_sum + SUM_W'(push_val) - SUM_W'(leaving);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_win <= '{default: '0};
            r_sum <= '0;
        end else if (i_cmd.push_in || i_cmd.push_zero) begin
            for (int k = MAX_TAPS - 1; k > 0; k--) begin
                r_win[k] <= r_win[k-1];
            end
            r_win[0] <= push_val;
            r_sum    <= n_sum;
        end
    end

    // divide by width as multiply by reciprocal, registered
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(r_sum) * PROD_W'(rbf_pkg::recip(5'(taps)));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_filtered <= r_prod[rbf_pkg::RECIP_SHIFT +: rbf_pkg::SAMPLE_W];
            r_row_done <= i_cmd.done_flag;
        end
    end

    assign o_taps     = taps;
    assign o_filtered = r_filtered;
    assign o_row_done = r_row_done;

endmodule

>>> hw/rtl/rbf_ctrl.sv
// sequencer for sample push, flush outputs and output handshake
module rbf_ctrl #(
    parameter int MAX_TAPS = 8,
    localparam int TAP_W = $clog2(MAX_TAPS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_row_end,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    input  logic             i_cfg_wr,
    input  logic [TAP_W-1:0] i_taps,
    output rbf_pkg::t_dp_cmd o_cmd
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic             r_valid;
    logic             r_last;
    logic [TAP_W-1:0] r_left;

    logic in_acc;
    logic slot_free;

    assign in_acc    = i_valid && (r_state == S_IDLE);
    assign slot_free = !r_valid || i_ready;

    always_comb begin
        o_cmd       = '0;
        o_cmd.clear = i_cfg_wr;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.push_in = in_acc;
            end
            S_MUL: begin
            end
            S_EMIT: begin
                if (slot_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.done_flag = r_last && (r_left == '0);
                    if (r_left != '0) begin
                        o_cmd.push_zero = 1'b1;
                    end else if (r_last) begin
                        o_cmd.clear = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_left  <= '0;
        end else begin
            if (o_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_last  <= i_row_end;
                        r_left  <= i_row_end ? (i_taps - TAP_W'(1)) : '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (slot_free) begin
                        if (r_left != '0) begin
                            r_left  <= r_left - TAP_W'(1);
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

endmodule

>>> hw/rtl/row_box_filter.sv
// row box filter top level: register port, controller and datapath
// a result passes through the running sum, product register and output register
// each sample steps through push, reciprocal multiply and output load
// a row_end sample adds width minus one flush results, each a zero push, multiply and load
// a stalled output holds the sequencer; the next sample is taken once the result is loaded
// reset: synchronous, active low; filter_size returns to 1, window and sum clear
module row_box_filter #(
    parameter int MAX_TAPS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_sample,
    input  logic        i_row_end,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_filtered,
    output logic        o_row_done,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int TAP_W = $clog2(MAX_TAPS + 1);

    logic [rbf_pkg::FSIZE_W-1:0] r_filter_size;
    logic                        cfg_wr;
    logic                        sel_fsize;
    logic [TAP_W-1:0]            taps;
    rbf_pkg::t_dp_cmd            cmd;

    // filter_size is the only register, selected whenever paddr[2] is zero
    assign sel_fsize = (paddr[2] == 1'b0);
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready && sel_fsize;
    assign prdata    = sel_fsize ? {28'd0, r_filter_size} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_size <= rbf_pkg::FSIZE_W'(1);
        end else if (cfg_wr) begin
            r_filter_size <= pwdata[rbf_pkg::FSIZE_W-1:0];
        end
    end

    // a write also empties the window (handled as a datapath clear)
    rbf_ctrl #(
        .MAX_TAPS(MAX_TAPS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_row_end (i_row_end),
        .o_ready   (o_ready),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .i_cfg_wr  (cfg_wr),
        .i_taps    (taps),
        .o_cmd     (cmd)
    );

    rbf_datapath #(
        .MAX_TAPS(MAX_TAPS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_sample      (i_sample),
        .i_filter_size (r_filter_size),
        .o_taps        (taps),
        .o_filtered    (o_filtered),
        .o_row_done    (o_row_done)
    );

endmodule

>>> hw/rtl/rbf_checker.sv
// port-level checks for the row box filter, bound to the top level
module rbf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_filtered,
    input logic       o_row_done
);
    // output register is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_filtered) && $stable(o_row_done)))
        else $error("stalled result changed");

    // one sample in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("sample taken while previous one in work");

    // a new result is only loaded while the sample side is busy
    a_load_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared without a sample in work");

endmodule

bind row_box_filter rbf_checker u_rbf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_filtered (o_filtered),
    .o_row_done (o_row_done)
);
